### sv/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg - shared definitions for the gain ramp multiplier
// field widths, command codes, parameter defaults and common types
// ----------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

    // fixed field widths
    localparam int GAIN_W = 24;
    localparam int LEN_W  = 13;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int MAX_BLOCK_DEF      = 4096;
    localparam int GAIN_FRAC_BITS_DEF = 20;

    // command codes carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SNAP   = 1'b1;

    typedef logic [GAIN_W-1:0] t_gain;
    typedef logic [LEN_W-1:0]  t_len;

endpackage

`default_nettype wire

### sv/gain_ramp_multiplier.sv
// ----------------------------------------------------------------------------
// gain_ramp_multiplier - audio gain stage with linear block ramp
// scales samples by a Q4.20 gain, sliding to a new target over one block
// ----------------------------------------------------------------------------
// usage:
//   input stream: tdata = {block_length, sample_in}, tuser = command
//   (0 = scale a sample, 1 = snap the current gain to the target).
//   output stream: tdata = sample_out, tlast = block_end. a snap item
//   gives no output item.
//   target_gain is written over the apb port at byte address 0 while the
//   block is idle; pready is always high.
// processing:
//   one item at a time. a sample at steady gain goes through accept, a
//   serial multiply, round and load; a sample in a ramp first passes
//   the serial ramp unit, a serial multiply followed by a restoring
//   divide. a snap is done at accept time.
//   the next item is accepted while a finished result waits at the output.
// reset:
//   target and current gain go to 1.0, the block position to zero, the
//   output register empties.
// stall:
//   a full output register holds its item; a finished result waits inside
//   the block and no new item is taken until it moves out.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_ramp_multiplier
    import grm_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK      = MAX_BLOCK_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int IN_DW  = ((SAMPLE_BITS + LEN_W + 7) / 8) * 8,
    localparam int OUT_DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // input items
    input  wire               i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire  [IN_DW-1:0]  i_s_axis_tdata,  // sample_in, block_length, zero pad
    input  wire               i_s_axis_tuser,  // command
    // result items
    output logic              o_m_axis_tvalid,
    input  wire               i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,  // sample_out, zero pad
    output logic              o_m_axis_tlast,  // block_end
    // configuration
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int POS_W = $clog2(MAX_BLOCK);
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam logic [31:0] MaxBlk  = 32'(MAX_BLOCK);
    localparam t_gain       GainOne = GAIN_W'(64'd1 << GAIN_FRAC_BITS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RAMP  = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // control state
    logic [1:0]             r_state;
    t_gain                  r_target;
    t_gain                  r_current;
    logic [POS_W-1:0]       r_pos;
    logic                   r_ramp_go;
    logic                   r_scale_go;
    logic                   r_out_valid;
    // payload
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last;
    logic                   r_down;
    t_len                   r_k;
    t_len                   r_n;
    t_gain                  r_gain;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_last;

    logic                   w_in_fire;
    logic                   w_cfg_wr;
    logic [SAMPLE_BITS-1:0] w_sample;
    t_len                   w_len;
    t_len                   w_n;
    logic                   w_last;
    logic                   w_eq;
    logic                   w_out_free;
    t_gain                  w_span;
    logic                   w_ramp_done;
    t_gain                  w_ramp_quot;
    logic                   w_scale_done;
    logic [SAMPLE_BITS-1:0] w_scale_res;

    // input field decode
    assign w_sample = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_len    = i_s_axis_tdata[SAMPLE_BITS+LEN_W-1:SAMPLE_BITS];

    // zero length counts as one, long blocks clamp to the maximum
    always_comb begin
        if (w_len == '0) begin
            w_n = LEN_W'(1);
        end else if (32'(w_len) > MaxBlk) begin
            w_n = LEN_W'(MAX_BLOCK);
        end else begin
            w_n = w_len;
        end
    end

    assign w_last = (CMP_W'(r_pos) >= (CMP_W'(w_n) - CMP_W'(1)));
    assign w_eq   = (r_current == r_target);

    // magnitude of the span; the direction is kept in r_down
    assign w_span = r_down ? (r_current - r_target) : (r_target - r_current);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // apb register file: one register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? 32'(r_target) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= GainOne;
            r_current   <= GainOne;
            r_pos       <= '0;
            r_ramp_go   <= 1'b0;
            r_scale_go  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ramp_go  <= 1'b0;
            r_scale_go <= 1'b0;

            if (w_cfg_wr) begin
                r_target <= pwdata[GAIN_W-1:0];
            end

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (i_s_axis_tuser == CMD_SNAP) begin
                            r_current <= r_target;
                            r_pos     <= '0;
                        end else begin
                            // block bookkeeping settles at accept time;
                            // the ramp still reads the old current gain,
                            // which only changes on the last sample or on a snap
                            if (w_last) begin
                                r_current <= r_target;
                                r_pos     <= '0;
                            end else begin
                                r_pos <= r_pos + POS_W'(1);
                            end
                            if (w_last || w_eq) begin
                                r_scale_go <= 1'b1;
                                r_state    <= ST_SCALE;
                            end else begin
                                r_ramp_go <= 1'b1;
                                r_state   <= ST_RAMP;
                            end
                        end
                    end
                end
                ST_RAMP: begin
                    if (w_ramp_done) begin
                        r_scale_go <= 1'b1;
                        r_state    <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (w_scale_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire && (i_s_axis_tuser == CMD_SAMPLE)) begin
            r_sample <= w_sample;
            r_last   <= w_last;
            r_down   <= (r_target < r_current);
            r_k      <= LEN_W'(r_pos) + LEN_W'(1);
            r_n      <= w_n;
            r_gain   <= r_target;
        end else if ((r_state == ST_RAMP) && w_ramp_done) begin
            // step toward the target, truncated toward zero
            r_gain <= r_down ? (r_current - w_ramp_quot) : (r_current + w_ramp_quot);
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_sample <= w_scale_res;
            r_out_last   <= r_last;
        end
    end

    grm_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ramp_go),
        .i_span  (w_span),
        .i_k     (r_k),
        .i_n     (r_n),
        .o_done  (w_ramp_done),
        .o_quot  (w_ramp_quot)
    );

    grm_scale #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_scale_go),
        .i_sample (r_sample),
        .i_gain   (r_gain),
        .o_done   (w_scale_done),
        .o_result (w_scale_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DW'(r_out_sample);
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### sv/grm_ramp.sv
// ----------------------------------------------------------------------------
// grm_ramp - serial ramp step unit
// computes span * k / n with a shift-add multiply and a restoring divide,
// one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module grm_ramp
    import grm_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_start,
    input  t_gain i_span,
    input  t_len  i_k,
    input  t_len  i_n,
    output logic  o_done,
    output t_gain o_quot
);

    localparam int PROD_W = GAIN_W + LEN_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]        r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [PROD_W-1:0] r_mcand;
    logic [PROD_W-1:0] r_acc;
    t_len              r_mplier;
    t_len              r_div;
    t_len              r_rem;

    logic [LEN_W:0]    w_rem_sh;
    logic              w_ge;
    logic [LEN_W:0]    w_rem_sub;

    // restoring divide step: bring down one dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh  = {r_rem, r_acc[PROD_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_div});
        w_rem_sub = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= CNT_W'(LEN_W);
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_cnt   <= CNT_W'(PROD_W);
                        r_phase <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_span);
                    r_acc    <= '0;
                    r_mplier <= i_k;
                    r_div    <= i_n;
                    r_rem    <= '0;
                end
            end
            PH_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            PH_DIV: begin
                // quotient bits shift in where dividend bits shift out
                r_rem <= w_ge ? w_rem_sub[LEN_W-1:0] : w_rem_sh[LEN_W-1:0];
                r_acc <= {r_acc[PROD_W-2:0], w_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_acc[GAIN_W-1:0];

endmodule

`default_nettype wire

### sv/grm_scale.sv
// ----------------------------------------------------------------------------
// grm_scale - serial sample scaler
// shift-add multiply of a signed sample by an unsigned gain, one gain bit
// per cycle, then round half up and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module grm_scale
    import grm_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [SAMPLE_BITS-1:0] i_sample,
    input  t_gain                 i_gain,
    output logic                  o_done,
    output logic [SAMPLE_BITS-1:0] o_result
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int CNT_W  = $clog2(GAIN_W + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;

    localparam logic signed [PROD_W-1:0] Half  =
        PROD_W'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] SatHi =
        {{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SatLo =
        {{(PROD_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]               r_phase;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_mcand;
    logic signed [PROD_W-1:0] r_acc;
    t_gain                    r_mplier;
    logic [SAMPLE_BITS-1:0]   r_result;

    logic signed [PROD_W-1:0] w_sum;
    logic signed [PROD_W-1:0] w_shr;
    logic [SAMPLE_BITS-1:0]   w_sat;

    always_comb begin
        w_sum = r_acc + Half;
        w_shr = w_sum >>> GAIN_FRAC_BITS;
        if (w_shr > SatHi) begin
            w_sat = SatHi[SAMPLE_BITS-1:0];
        end else if (w_shr < SatLo) begin
            w_sat = SatLo[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_shr[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= CNT_W'(GAIN_W);
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_phase <= PH_RND;
                    end
                end
                PH_RND: begin
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(signed'(i_sample));
                    r_acc    <= '0;
                    r_mplier <= i_gain;
                end
            end
            PH_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
            end
            PH_RND: begin
                r_result <= w_sat;
            end
            default: begin
                r_result <= r_result;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
